// ----- hdl/two_street_traffic_light_sequencer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the traffic light sequencer
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef TWO_STREET_TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH
`define TWO_STREET_TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication
`define TLSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlsq: same-cycle check failed");

// Next-cycle implication
`define TLSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlsq: next-cycle check failed");

`endif

// ----- hdl/tlsq_pkg.sv -----
// ---------------------------------------------------------------------------
// tlsq_pkg
// Types and constants shared by the traffic light sequencer modules.
// ---------------------------------------------------------------------------
package tlsq_pkg;

  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W   = 8;

  typedef enum logic [1:0] {
    LAMP_OFF   = 2'd0,
    LAMP_GREEN = 2'd1,
    LAMP_AMBER = 2'd2,
    LAMP_RED   = 2'd3
  } lamp_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_FORCE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_A_GREEN_END = 2'd0,
    CFG_A_AMBER_END = 2'd1,
    CFG_B_GREEN_END = 2'd2,
    CFG_CYCLE_END   = 2'd3
  } cfg_reg_t;

  localparam logic              STREET_A = 1'b0;
  localparam logic [CFG_W-1:0]  A_GREEN_END_RST = 8'd20;
  localparam logic [CFG_W-1:0]  A_AMBER_END_RST = 8'd25;
  localparam logic [CFG_W-1:0]  B_GREEN_END_RST = 8'd45;
  localparam logic [CFG_W-1:0]  CYCLE_END_RST   = 8'd50;

  typedef struct packed {
    op_t  op;
    logic street;
  } cmd_t;

  typedef struct packed {
    lamp_t light_a;
    lamp_t light_b;
  } lights_t;

  typedef struct packed {
    logic [CFG_W-1:0] a_green_end;
    logic [CFG_W-1:0] a_amber_end;
    logic [CFG_W-1:0] b_green_end;
    logic [CFG_W-1:0] cycle_end;
  } timing_t;

  typedef struct packed {
    logic [COUNT_W-1:0] phase_count;
    lamp_t              lamp_a;
    lamp_t              lamp_b;
  } seq_state_t;

endpackage

// ----- hdl/two_street_traffic_light_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// two_street_traffic_light_sequencer_core
// Two-street crossing controller driven by tick and command transfers.
// ---------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one tick, on, off or
//   force-clear command per transfer. lights channel
//   (lights_valid/lights_stall/lights) returns both lamp states after
//   every command, one result per command, in order.
//   A command goes from the transfer into the command register and then
//   into the result register, where the counter and lamp state are
//   updated as the result is loaded; lights_valid rises as the result
//   register loads. One command is taken per cycle while the receiver
//   does not stall; the lamp state register feeds its own next value
//   through a single compare-and-update step.
//   cmd_stall rises only when both registers hold data and the receiver
//   stalls; a stalled result holds its value. Reset clears both lamps to
//   off, the counter to zero and the timing registers to 20, 25, 45 and
//   50 ticks. The user must write the timing registers through
//   cfg_write/cfg_index/cfg_data while the block is idle; it is not enforced.
// ---------------------------------------------------------------------------
module two_street_traffic_light_sequencer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  tlsq_pkg::cmd_t      cmd,
  output logic                lights_valid,
  input  logic                lights_stall,
  output tlsq_pkg::lights_t   lights,
  input  logic                cfg_write,
  input  tlsq_pkg::cfg_reg_t  cfg_index,
  input  logic [7:0]          cfg_data
);
  import tlsq_pkg::*;

  `include "two_street_traffic_light_sequencer_core_assert.svh"

  timing_t    timing;
  cmd_t       cmd_q;
  logic       cmd_q_valid;
  seq_state_t state;
  seq_state_t state_next;
  logic       out_free;
  logic       stage_adv;
  logic       cmd_take;

  tlsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  tlsq_step u_step (
    .cmd    (cmd_q),
    .cur    (state),
    .timing (timing),
    .nxt    (state_next)
  );

  assign out_free  = !lights_valid || !lights_stall;
  assign stage_adv = cmd_q_valid && out_free;
  assign cmd_stall = cmd_q_valid && !out_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (!cmd_q_valid || out_free) begin
      cmd_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd;
    end
  end

  // sequencer state, updated as the result register loads
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase_count <= '0;
      state.lamp_a      <= LAMP_OFF;
      state.lamp_b      <= LAMP_OFF;
    end else if (stage_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lights_valid <= 1'b0;
    end else if (out_free) begin
      lights_valid <= cmd_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      lights.light_a <= state_next.lamp_a;
      lights.light_b <= state_next.lamp_b;
    end
  end

  `TLSQ_ASSERT_NOW(a_off_pair, state.lamp_a == LAMP_OFF, state.lamp_b == LAMP_OFF)
  `TLSQ_ASSERT_NEXT(a_result_matches_state, stage_adv,
                    lights.light_a == state.lamp_a && lights.light_b == state.lamp_b)
  `TLSQ_ASSERT_NEXT(a_held_cmd_kept, cmd_q_valid && !out_free, cmd_q_valid && $stable(cmd_q))
  `TLSQ_ASSERT_NOW(a_stall_only_full, cmd_stall, cmd_q_valid && lights_valid && lights_stall)

endmodule

// ----- hdl/tlsq_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// tlsq_cfg_regs
// Timing registers written through the plain configuration port.
// ---------------------------------------------------------------------------
module tlsq_cfg_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  tlsq_pkg::cfg_reg_t       cfg_index,
  input  logic [7:0]               cfg_data,
  output tlsq_pkg::timing_t        timing
);
  import tlsq_pkg::*;

  timing_t timing_next;

  always_comb begin
    timing_next = timing;
    if (cfg_write) begin
      case (cfg_index)
        CFG_A_GREEN_END: timing_next.a_green_end = cfg_data;
        CFG_A_AMBER_END: timing_next.a_amber_end = cfg_data;
        CFG_B_GREEN_END: timing_next.b_green_end = cfg_data;
        CFG_CYCLE_END:   timing_next.cycle_end   = cfg_data;
        default:         timing_next = timing;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.a_green_end <= A_GREEN_END_RST;
      timing.a_amber_end <= A_AMBER_END_RST;
      timing.b_green_end <= B_GREEN_END_RST;
      timing.cycle_end   <= CYCLE_END_RST;
    end else begin
      timing <= timing_next;
    end
  end

endmodule

// ----- hdl/tlsq_step.sv -----
// ---------------------------------------------------------------------------
// tlsq_step
// Next-state logic: applies one command to the counter and lamp state.
// ---------------------------------------------------------------------------
module tlsq_step (
  input  tlsq_pkg::cmd_t       cmd,
  input  tlsq_pkg::seq_state_t cur,
  input  tlsq_pkg::timing_t    timing,
  output tlsq_pkg::seq_state_t nxt
);
  import tlsq_pkg::*;

  logic               lights_on;
  logic [COUNT_W-1:0] count_inc;

  assign lights_on = (cur.lamp_a != LAMP_OFF);
  assign count_inc = cur.phase_count + COUNT_W'(1);

  always_comb begin
    nxt = cur;
    case (cmd.op)
      OP_TICK: begin
        if (lights_on) begin
          nxt.phase_count = count_inc;
          // first matching end point wins
          if (count_inc == timing.a_green_end) begin
            nxt.lamp_a = LAMP_AMBER;
          end else if (count_inc == timing.a_amber_end) begin
            nxt.lamp_a = LAMP_RED;
            nxt.lamp_b = LAMP_GREEN;
          end else if (count_inc == timing.b_green_end) begin
            nxt.lamp_b = LAMP_AMBER;
          end else if (count_inc == timing.cycle_end) begin
            nxt.lamp_a      = LAMP_GREEN;
            nxt.lamp_b      = LAMP_RED;
            nxt.phase_count = '0;
          end
        end
      end
      OP_ON: begin
        if (!lights_on) begin
          nxt.lamp_a      = LAMP_GREEN;
          nxt.lamp_b      = LAMP_RED;
          nxt.phase_count = '0;
        end
      end
      OP_OFF: begin
        // counter keeps its value
        if (lights_on) begin
          nxt.lamp_a = LAMP_OFF;
          nxt.lamp_b = LAMP_OFF;
        end
      end
      OP_FORCE: begin
        if (lights_on) begin
          if (cmd.street == STREET_A) begin
            if (cur.lamp_b == LAMP_GREEN) begin
              nxt.lamp_b      = LAMP_AMBER;
              nxt.phase_count = timing.b_green_end;
            end else begin
              nxt.lamp_b      = LAMP_RED;
              nxt.lamp_a      = LAMP_GREEN;
              nxt.phase_count = '0;
            end
          end else begin
            if (cur.lamp_a == LAMP_GREEN) begin
              nxt.lamp_a      = LAMP_AMBER;
              nxt.phase_count = timing.a_green_end;
            end else begin
              nxt.lamp_a      = LAMP_RED;
              nxt.lamp_b      = LAMP_GREEN;
              nxt.phase_count = timing.a_amber_end;
            end
          end
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule
